FILE: sv/pps_pkg.sv
`default_nettype none

package pps_pkg;

    // task limits and field widths
    localparam int MAX_TASKS = 32;
    localparam int ID_W      = 5;
    localparam int BURST_W   = 16;
    localparam int PRI_W     = 8;
    localparam int TIME_W    = 32;

    // item command codes
    typedef enum logic {
        CMD_ARRIVE = 1'b0,
        CMD_TICK   = 1'b1
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_DISPATCH = 2'd1,
        ST_DROP     = 2'd2,
        ST_IDLE     = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC
    } t_state;

    // one ready store entry
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] remaining;
        logic [PRI_W-1:0]   prio;
    } t_entry;

    // one result item
    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   dispatched_id;
        logic [TIME_W-1:0] start_time;
        logic              was_preempted;
        logic [ID_W-1:0]   preempted_id;
        logic              completed;
        logic [ID_W-1:0]   completed_id;
    } t_result;

    // task id wrap table, built at elaboration
    typedef logic [ID_W-1:0] t_id_table [2**ID_W];

    function automatic t_id_table build_id_table();
        t_id_table tbl;
        for (int k = 0; k < 2**ID_W; k++) begin
            tbl[k] = ID_W'(k % MAX_TASKS);
        end
        return tbl;
    endfunction

    localparam t_id_table ID_TABLE = build_id_table();

endpackage

`default_nettype wire

FILE: sv/pps_ifs.sv
`default_nettype none

// task channel: arrivals and ticks
interface pps_task_if import pps_pkg::*;;
    logic               valid;
    logic               ready;
    t_cmd               command;
    logic [ID_W-1:0]    task_id;
    logic [BURST_W-1:0] burst_length;
    logic [PRI_W-1:0]   task_priority;

    modport source (
        output valid, command, task_id, burst_length, task_priority,
        input  ready
    );
    modport sink (
        input  valid, command, task_id, burst_length, task_priority,
        output ready
    );
endinterface

// result channel
interface pps_result_if import pps_pkg::*;;
    logic              valid;
    logic              ready;
    t_status           status;
    logic [ID_W-1:0]   dispatched_id;
    logic [TIME_W-1:0] start_time;
    logic              was_preempted;
    logic [ID_W-1:0]   preempted_id;
    logic              completed;
    logic [ID_W-1:0]   completed_id;

    modport source (
        output valid, status, dispatched_id, start_time, was_preempted,
               preempted_id, completed, completed_id,
        input  ready
    );
    modport sink (
        input  valid, status, dispatched_id, start_time, was_preempted,
               preempted_id, completed, completed_id,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/preemptive_priority_scheduler_top.sv
// channel   | dir | handshake      | item
// i_task    | in  | valid / ready  | command, task_id, burst_length, task_priority
// o_result  | out | valid / ready  | status, dispatched_id, start_time, was_preempted,
//           |     |                | preempted_id, completed, completed_id
//
// each item is taken in the idle state, then one compare unit walks the ready store
// one slot per cycle through the single read port of the store memory, then the
// exec state applies the update; the next item is accepted only back in idle.
// the result sits in an output register, so a stalled result only holds the
// block once the next item is ready to post its own result.
// reset (synchronous, active low) empties the store and clears the running task
// and the time count; it needs no clearing pass.
`default_nettype none

module preemptive_priority_scheduler_top import pps_pkg::*; #(
    parameter int READY_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pps_task_if.sink       i_task,
    pps_result_if.source   o_result
);

    localparam int IW = $clog2(READY_DEPTH);
    localparam int CW = $clog2(READY_DEPTH + 1);

    // sequencer
    t_state r_state;
    t_state n_state;

    // latched item
    t_cmd   r_cmd;
    t_entry r_new;

    // scan pipeline
    logic [CW-1:0] r_idx;
    logic          r_pend;
    logic [IW-1:0] r_pidx;
    t_entry        r_rd;
    logic          r_best_found;
    logic [IW-1:0] r_best_idx;
    t_entry        r_best;
    logic          r_free_found;
    logic [IW-1:0] r_free_idx;

    // ready store and running task
    t_entry                 r_mem [READY_DEPTH];
    logic [READY_DEPTH-1:0] r_valid;
    logic                   r_run_valid;
    t_entry                 r_run;
    logic [TIME_W-1:0]      r_time;

    // output register
    logic    r_out_valid;
    t_result r_out;

    // combinational control
    logic          in_ready;
    logic          scan_last;
    logic          out_free;
    logic          accept;
    logic          exec_fire;
    logic          hit_best;
    logic          hit_free;
    logic [IW-1:0] rd_addr;

    // tick evaluation
    logic    done;
    logic    run_live;
    logic    disp;
    logic    n_run_valid;
    t_entry  n_run;
    t_result res;

    // store write port
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_task.valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (scan_last) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        in_ready  = 1'b0;
        exec_fire = 1'b0;
        case (r_state)
            S_IDLE:  in_ready  = 1'b1;
            S_SCAN:  in_ready  = 1'b0;
            S_EXEC:  exec_fire = out_free;
            default: in_ready  = 1'b0;
        endcase
    end

    assign scan_last = (r_idx == CW'(READY_DEPTH));
    assign out_free  = !r_out_valid || o_result.ready;
    assign accept    = in_ready && i_task.valid;
    assign rd_addr   = scan_last ? '0 : r_idx[IW-1:0];

    // shared compare unit: most urgent entry and lowest free slot
    assign hit_best = (r_state == S_SCAN) && r_pend && r_valid[r_pidx]
                      && (!r_best_found || (r_rd.prio < r_best.prio));
    assign hit_free = (r_state == S_SCAN) && r_pend && !r_valid[r_pidx]
                      && !r_free_found;

    // tick: completion, dispatch or preemption, then countdown
    always_comb begin
        done        = r_run_valid && (r_run.remaining == '0);
        run_live    = r_run_valid && !done;
        disp        = r_best_found && (!run_live || (r_best.prio < r_run.prio));
        n_run_valid = run_live || disp;
        n_run       = disp ? r_best : r_run;
        if (n_run_valid && (n_run.remaining != '0)) begin
            n_run.remaining = n_run.remaining - BURST_W'(1);
        end
    end

    // result item
    always_comb begin
        res = '0;
        if (r_cmd == CMD_ARRIVE) begin
            res.status = r_free_found ? ST_NONE : ST_DROP;
        end else begin
            res.completed    = done;
            res.completed_id = done ? r_run.id : '0;
            if (disp) begin
                res.status        = ST_DISPATCH;
                res.dispatched_id = r_best.id;
                res.start_time    = r_time;
                res.was_preempted = run_live;
                res.preempted_id  = run_live ? r_run.id : '0;
            end else begin
                res.status = run_live ? ST_NONE : ST_IDLE;
            end
        end
    end

    // store write: new arrival, or preempted task into the vacated slot
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_free_idx;
        wr_data = r_new;
        if (exec_fire) begin
            if (r_cmd == CMD_ARRIVE) begin
                wr_en = r_free_found;
            end else if (disp && run_live) begin
                wr_en   = 1'b1;
                wr_addr = r_best_idx;
                wr_data = r_run;
            end
        end
    end

    // ready store memory
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rd <= r_mem[rd_addr];
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_best_found <= 1'b0;
            r_free_found <= 1'b0;
            r_valid      <= '0;
            r_run_valid  <= 1'b0;
            r_run        <= '0;
            r_time       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            // latch the item and restart the scan
            if (accept) begin
                r_cmd        <= i_task.command;
                r_new        <= '{id:        ID_TABLE[i_task.task_id],
                                  remaining: i_task.burst_length,
                                  prio:      i_task.task_priority};
                r_idx        <= '0;
                r_pend       <= 1'b0;
                r_best_found <= 1'b0;
                r_free_found <= 1'b0;
            end

            // walk the store one slot per cycle
            if (r_state == S_SCAN) begin
                r_pend <= !scan_last;
                r_pidx <= r_idx[IW-1:0];
                if (!scan_last) r_idx <= r_idx + CW'(1);
                if (hit_best) begin
                    r_best_found <= 1'b1;
                    r_best_idx   <= r_pidx;
                    r_best       <= r_rd;
                end
                if (hit_free) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_pidx;
                end
            end

            // apply the update
            if (exec_fire) begin
                if (r_cmd == CMD_ARRIVE) begin
                    if (r_free_found) r_valid[r_free_idx] <= 1'b1;
                end else begin
                    if (disp && !run_live) r_valid[r_best_idx] <= 1'b0;
                    r_run_valid <= n_run_valid;
                    r_run       <= n_run;
                    r_time      <= r_time + TIME_W'(1);
                end
            end

            // output register
            if (exec_fire) begin
                r_out_valid <= 1'b1;
                r_out       <= res;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ports
    assign i_task.ready           = in_ready;
    assign o_result.valid         = r_out_valid;
    assign o_result.status        = r_out.status;
    assign o_result.dispatched_id = r_out.dispatched_id;
    assign o_result.start_time    = r_out.start_time;
    assign o_result.was_preempted = r_out.was_preempted;
    assign o_result.preempted_id  = r_out.preempted_id;
    assign o_result.completed     = r_out.completed;
    assign o_result.completed_id  = r_out.completed_id;

endmodule

`default_nettype wire

FILE: sv/pps_checker.sv
`default_nettype none

module pps_checker import pps_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input t_status           i_status,
    input logic [ID_W-1:0]   i_dispatched_id,
    input logic [TIME_W-1:0] i_start_time,
    input logic              i_was_preempted,
    input logic [ID_W-1:0]   i_preempted_id,
    input logic              i_completed,
    input logic [ID_W-1:0]   i_completed_id
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_status) && $stable(i_dispatched_id))
        else $error("stalled result changed");

    // one item at a time: busy right after an acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item accepted while scan in progress");

    // dispatch fields are zero unless a task was dispatched
    a_no_dispatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_DISPATCH) |->
            (i_dispatched_id == '0) && (i_start_time == '0)
            && !i_was_preempted && (i_preempted_id == '0))
        else $error("dispatch fields set without a dispatch");

    // completion id only with completion
    a_completed_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_completed |-> (i_completed_id == '0))
        else $error("completed id without completion");

    // a dropped arrival touches no running task
    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_DROP) |-> !i_completed)
        else $error("dropped arrival reported a completion");

endmodule

bind preemptive_priority_scheduler_top pps_checker u_pps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_task.valid),
    .i_in_ready      (i_task.ready),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_status        (o_result.status),
    .i_dispatched_id (o_result.dispatched_id),
    .i_start_time    (o_result.start_time),
    .i_was_preempted (o_result.was_preempted),
    .i_preempted_id  (o_result.preempted_id),
    .i_completed     (o_result.completed),
    .i_completed_id  (o_result.completed_id)
);

`default_nettype wire
